// File: src/tsnb_pkg.sv
package tsnb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CH_W      = 17;
	localparam int ADDR_W    = 14;
	localparam int SIDE_W    = 8;
	localparam int POS_W     = 7;
	localparam int PROD_W    = 26;
	localparam int MAX_SIDE  = 128;

	localparam logic [CH_W-1:0]      ONE_FX  = CH_W'(1) << FRAC_BITS;
	localparam logic [PROD_W-1:0]    HALF_FX = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [SIDE_W-1:0]    SIDE_MAX = SIDE_W'(MAX_SIDE);

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic FILT_NEAREST  = 1'b0;
	localparam logic FILT_BILINEAR = 1'b1;

	localparam logic [2:0] CFG_FILTER   = 3'd0;
	localparam logic [2:0] CFG_CHANNELS = 3'd1;
	localparam logic [2:0] CFG_WIDTH    = 3'd2;
	localparam logic [2:0] CFG_HEIGHT   = 3'd3;
	localparam logic [2:0] CFG_PRESENT  = 3'd4;

	localparam logic [2:0] CH_GREY       = 3'd1;
	localparam logic [2:0] CH_GREY_ALPHA = 3'd2;
	localparam logic [2:0] CH_RGB        = 3'd3;
	localparam logic [2:0] CH_RGBA       = 3'd4;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
	} texel_t;

	// byte c maps to (2c+1) << 7 at 16 fraction bits
	function automatic logic [CH_W-1:0] byte_to_fx(input logic [7:0] c);
		return CH_W'({c, 1'b1}) << (FRAC_BITS - 9);
	endfunction

	function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] raw);
		logic [SIDE_W-1:0] s;
		s = raw;
		if (raw == '0) s = SIDE_W'(1);
		else if (raw > SIDE_MAX) s = SIDE_MAX;
		return s;
	endfunction

endpackage

// File: src/texture_sampler_nearest_bilinear_top.sv
// one result per sample, none per write
// one item per cycle unless stalled; four replicated stores give four reads per cycle
// texel writes land in the stores as they leave stage 3, ahead of any later sample
// a stalled output backs up stage by stage, bubbles are squeezed out
// arst_n clears the valid bits and config registers (filter 0, 4 channels, 1x1, absent)
// texel stores are not reset and hold garbage until written
module texture_sampler_nearest_bilinear_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [13:0] texel_index,
	input  logic [7:0]  byte_zero,
	input  logic [7:0]  byte_one,
	input  logic [7:0]  byte_two,
	input  logic [7:0]  byte_three,
	input  logic signed [31:0] coord_u,
	input  logic signed [31:0] coord_v,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] red_out,
	output logic [16:0] green_out,
	output logic [16:0] blue_out,
	output logic [16:0] alpha_out
);

	localparam int CH_W   = tsnb_pkg::CH_W;
	localparam int ADDR_W = tsnb_pkg::ADDR_W;
	localparam int SIDE_W = tsnb_pkg::SIDE_W;
	localparam int POS_W  = tsnb_pkg::POS_W;
	localparam int PROD_W = tsnb_pkg::PROD_W;
	localparam int FB     = tsnb_pkg::FRAC_BITS;
	localparam int DEPTH  = 1 << ADDR_W;

	function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] p,
			input logic [CH_W-1:0] q, input logic [FB-1:0] t);
		logic [CH_W-1:0]    d;
		logic [CH_W+FB-1:0] m;
		logic [CH_W-1:0]    r;
		d = (q >= p) ? (q - p) : (p - q);
		m = (CH_W+FB)'(d) * (CH_W+FB)'(t);
		r = (q >= p) ? (p + m[CH_W+FB-1:FB]) : (p - m[CH_W+FB-1:FB]);
		return r;
	endfunction

	// configuration
	logic              filter_q;
	logic [2:0]        channels_q;
	logic [SIDE_W-1:0] width_q;
	logic [SIDE_W-1:0] height_q;
	logic              present_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q   <= tsnb_pkg::FILT_NEAREST;
			channels_q <= tsnb_pkg::CH_RGBA;
			width_q    <= SIDE_W'(1);
			height_q   <= SIDE_W'(1);
			present_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tsnb_pkg::CFG_FILTER:   filter_q   <= cfg_data[0];
				tsnb_pkg::CFG_CHANNELS: channels_q <= cfg_data[2:0];
				tsnb_pkg::CFG_WIDTH:    width_q    <= cfg_data;
				tsnb_pkg::CFG_HEIGHT:   height_q   <= cfg_data;
				tsnb_pkg::CFG_PRESENT:  present_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [SIDE_W-1:0] w_side, h_side;
	assign w_side = tsnb_pkg::side_of(width_q);
	assign h_side = tsnb_pkg::side_of(height_q);

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	assign rdy6 = !v_s6 || !out_stall;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	// stage 1: texel expansion and coordinate scaling
	tsnb_pkg::texel_t  tex_in;
	logic [SIDE_W-1:0] u_fac, v_fac;
	logic [FB:0]       v_op;
	logic [PROD_W-1:0] pu_in, pv_in, half_add;
	logic [CH_W-1:0]   b0, b1, b2, b3;

	always_comb begin
		b0 = tsnb_pkg::byte_to_fx(byte_zero);
		b1 = tsnb_pkg::byte_to_fx(byte_one);
		b2 = tsnb_pkg::byte_to_fx(byte_two);
		b3 = tsnb_pkg::byte_to_fx(byte_three);
		tex_in = '0;
		case (channels_q)
			tsnb_pkg::CH_GREY:       tex_in = '{b0, b0, b0, tsnb_pkg::ONE_FX};
			tsnb_pkg::CH_GREY_ALPHA: tex_in = '{b0, b0, b0, b1};
			tsnb_pkg::CH_RGB:        tex_in = '{b0, b1, b2, tsnb_pkg::ONE_FX};
			tsnb_pkg::CH_RGBA:       tex_in = '{b0, b1, b2, b3};
			default:                 tex_in = '0;
		endcase
		// nearest flips v and scales by side-1 with rounding
		if (filter_q == tsnb_pkg::FILT_BILINEAR) begin
			u_fac    = w_side;
			v_fac    = h_side;
			v_op     = {1'b0, coord_v[FB-1:0]};
			half_add = '0;
		end else begin
			u_fac    = w_side - SIDE_W'(1);
			v_fac    = h_side - SIDE_W'(1);
			v_op     = (FB+1)'(tsnb_pkg::ONE_FX) - {1'b0, coord_v[FB-1:0]};
			half_add = tsnb_pkg::HALF_FX;
		end
		pu_in = PROD_W'(coord_u[FB-1:0]) * PROD_W'(u_fac) + half_add;
		pv_in = PROD_W'(v_op) * PROD_W'(v_fac) + half_add;
	end

	logic               op_s1;
	logic [ADDR_W-1:0]  idx_s1;
	tsnb_pkg::texel_t   tex_s1;
	logic [PROD_W-1:0]  pu_s1, pv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (rdy1) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1  <= opcode;
			idx_s1 <= texel_index;
			tex_s1 <= tex_in;
			pu_s1  <= pu_in;
			pv_s1  <= pv_in;
		end
	end

	// stage 2: integer positions, wrap and clamp
	logic [POS_W-1:0]  x0_c, x1_c, y0_c, y1_c;
	logic [FB-1:0]     ta_c, tb_c;
	logic [PROD_W-FB-1:0] xn, yn;
	logic [SIDE_W-1:0] xb1, yb1;

	always_comb begin
		xn  = pu_s1[PROD_W-1:FB];
		yn  = pv_s1[PROD_W-1:FB];
		xb1 = SIDE_W'(pu_s1[FB+POS_W-1:FB]) + SIDE_W'(pu_s1[FB-1:0] != '0);
		yb1 = SIDE_W'(pv_s1[FB+POS_W-1:FB]) + SIDE_W'(pv_s1[FB-1:0] != '0);
		if (filter_q == tsnb_pkg::FILT_BILINEAR) begin
			x0_c = pu_s1[FB+POS_W-1:FB];
			y0_c = pv_s1[FB+POS_W-1:FB];
			x1_c = (xb1 >= w_side) ? '0 : xb1[POS_W-1:0];
			y1_c = (yb1 >= h_side) ? '0 : yb1[POS_W-1:0];
			ta_c = pu_s1[FB-1:0];
			tb_c = pv_s1[FB-1:0];
		end else begin
			x0_c = (xn >= (PROD_W-FB)'(w_side)) ? POS_W'(w_side - SIDE_W'(1)) : xn[POS_W-1:0];
			y0_c = (yn >= (PROD_W-FB)'(h_side)) ? POS_W'(h_side - SIDE_W'(1)) : yn[POS_W-1:0];
			x1_c = x0_c;
			y1_c = y0_c;
			ta_c = '0;
			tb_c = '0;
		end
	end

	logic              op_s2;
	logic [ADDR_W-1:0] idx_s2;
	tsnb_pkg::texel_t  tex_s2;
	logic [POS_W-1:0]  x0_s2, x1_s2, y0_s2, y1_s2;
	logic [FB-1:0]     ta_s2, tb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (rdy2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			tex_s2 <= tex_s1;
			x0_s2  <= x0_c;
			x1_s2  <= x1_c;
			y0_s2  <= y0_c;
			y1_s2  <= y1_c;
			ta_s2  <= ta_c;
			tb_s2  <= tb_c;
		end
	end

	// stage 3: linear addresses
	logic [ADDR_W-1:0] row0, row1;
	assign row0 = ADDR_W'(ADDR_W'(y0_s2) * ADDR_W'(w_side));
	assign row1 = ADDR_W'(ADDR_W'(y1_s2) * ADDR_W'(w_side));

	logic              op_s3;
	tsnb_pkg::texel_t  tex_s3;
	logic [ADDR_W-1:0] a00_s3, a10_s3, a01_s3, a11_s3;
	logic [FB-1:0]     ta_s3, tb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (rdy3) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			op_s3  <= op_s2;
			tex_s3 <= tex_s2;
			a00_s3 <= (op_s2 == tsnb_pkg::OP_WRITE) ? idx_s2 : row0 + ADDR_W'(x0_s2);
			a10_s3 <= row0 + ADDR_W'(x1_s2);
			a01_s3 <= row1 + ADDR_W'(x0_s2);
			a11_s3 <= row1 + ADDR_W'(x1_s2);
			ta_s3  <= ta_s2;
			tb_s3  <= tb_s2;
		end
	end

	// stage 4: texel stores, one copy per corner, every write goes to all four
	tsnb_pkg::texel_t mem00_q [DEPTH];
	tsnb_pkg::texel_t mem10_q [DEPTH];
	tsnb_pkg::texel_t mem01_q [DEPTH];
	tsnb_pkg::texel_t mem11_q [DEPTH];

	logic wr_en;
	assign wr_en = rdy4 && v_s3 && (op_s3 == tsnb_pkg::OP_WRITE);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem00_q[a00_s3] <= tex_s3;
			mem10_q[a00_s3] <= tex_s3;
			mem01_q[a00_s3] <= tex_s3;
			mem11_q[a00_s3] <= tex_s3;
		end
	end

	tsnb_pkg::texel_t p00_s4, p10_s4, p01_s4, p11_s4;
	logic [FB-1:0]    ta_s4, tb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (rdy4) v_s4 <= v_s3 && (op_s3 == tsnb_pkg::OP_SAMPLE);
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			p00_s4 <= mem00_q[a00_s3];
			p10_s4 <= mem10_q[a10_s3];
			p01_s4 <= mem01_q[a01_s3];
			p11_s4 <= mem11_q[a11_s3];
			ta_s4  <= ta_s3;
			tb_s4  <= tb_s3;
		end
	end

	// stage 5: horizontal blends
	tsnb_pkg::texel_t r1_s5, r2_s5;
	logic [FB-1:0]    tb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (rdy5) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			r1_s5.r <= lerp(p00_s4.r, p10_s4.r, ta_s4);
			r1_s5.g <= lerp(p00_s4.g, p10_s4.g, ta_s4);
			r1_s5.b <= lerp(p00_s4.b, p10_s4.b, ta_s4);
			r1_s5.a <= lerp(p00_s4.a, p10_s4.a, ta_s4);
			r2_s5.r <= lerp(p01_s4.r, p11_s4.r, ta_s4);
			r2_s5.g <= lerp(p01_s4.g, p11_s4.g, ta_s4);
			r2_s5.b <= lerp(p01_s4.b, p11_s4.b, ta_s4);
			r2_s5.a <= lerp(p01_s4.a, p11_s4.a, ta_s4);
			tb_s5   <= tb_s4;
		end
	end

	// stage 6: vertical blend into the output register, zero while no texture is present
	tsnb_pkg::texel_t res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (rdy6) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (rdy6) begin
			if (present_q) begin
				res_s6.r <= lerp(r1_s5.r, r2_s5.r, tb_s5);
				res_s6.g <= lerp(r1_s5.g, r2_s5.g, tb_s5);
				res_s6.b <= lerp(r1_s5.b, r2_s5.b, tb_s5);
				res_s6.a <= lerp(r1_s5.a, r2_s5.a, tb_s5);
			end else begin
				res_s6 <= '0;
			end
		end
	end

	assign out_valid = v_s6;
	assign red_out   = res_s6.r;
	assign green_out = res_s6.g;
	assign blue_out  = res_s6.b;
	assign alpha_out = res_s6.a;

`ifndef SYNTH
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted transfer did not reach stage 1");

	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && op_s2 == tsnb_pkg::OP_SAMPLE) |->
		(SIDE_W'(x0_s2) < w_side && SIDE_W'(x1_s2) < w_side))
		else $error("column outside texture");

	a_y_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && op_s2 == tsnb_pkg::OP_SAMPLE) |->
		(SIDE_W'(y0_s2) < h_side && SIDE_W'(y1_s2) < h_side))
		else $error("row outside texture");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !present_q) |->
		(red_out == '0 && green_out == '0 && blue_out == '0 && alpha_out == '0))
		else $error("sample without texture not zero");
`endif

endmodule

// File: tb/sv/texture_sampler_nearest_bilinear_top_tb.sv
`timescale 1ns / 1ps

module texture_sampler_nearest_bilinear_top_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = tsnb_pkg::OP_WRITE;
	logic [13:0] texel_index = '0;
	logic [7:0] byte_zero = '0, byte_one = '0, byte_two = '0, byte_three = '0;
	logic signed [31:0] coord_u = '0, coord_v = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [16:0] red_out, green_out, blue_out, alpha_out;

	texture_sampler_nearest_bilinear_top u_top (.*);

	// predictor state
	tsnb_pkg::texel_t texel_mem [16384];
	logic filt_q = tsnb_pkg::FILT_NEAREST;
	logic [2:0] chan_q = tsnb_pkg::CH_RGBA;
	logic [7:0] width_q = 8'd1, height_q = 8'd1;
	logic present_q = 1'b0;
	tsnb_pkg::texel_t rgba_pending[$];
	int mismatches = 0;
	bit calm = 1'b0;

	initial forever #4 clk = ~clk;

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 27);

	function automatic longint unsigned clamp_side(logic [7:0] raw);
		if (raw == 0) return 1;
		if (raw > tsnb_pkg::MAX_SIDE) return tsnb_pkg::MAX_SIDE;
		return raw;
	endfunction

	function automatic logic [16:0] expand_byte(logic [7:0] c);
		longint unsigned v;
		v = ((longint'(c) * 2 + 1) << tsnb_pkg::FRAC_BITS) >> 9;
		return v[16:0];
	endfunction

	function automatic longint unsigned blend(longint unsigned p, longint unsigned q,
			longint unsigned t);
		if (q >= p) return p + (((q - p) * t) >> tsnb_pkg::FRAC_BITS);
		return p - (((p - q) * t) >> tsnb_pkg::FRAC_BITS);
	endfunction

	function automatic tsnb_pkg::texel_t expand_texel(logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2, logic [7:0] b3);
		tsnb_pkg::texel_t t;
		t = '0;
		case (chan_q)
			tsnb_pkg::CH_GREY: t = '{expand_byte(b0), expand_byte(b0), expand_byte(b0),
				tsnb_pkg::ONE_FX};
			tsnb_pkg::CH_GREY_ALPHA: t = '{expand_byte(b0), expand_byte(b0),
				expand_byte(b0), expand_byte(b1)};
			tsnb_pkg::CH_RGB: t = '{expand_byte(b0), expand_byte(b1), expand_byte(b2),
				tsnb_pkg::ONE_FX};
			tsnb_pkg::CH_RGBA: t = '{expand_byte(b0), expand_byte(b1), expand_byte(b2),
				expand_byte(b3)};
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic tsnb_pkg::texel_t sample_texel(logic [31:0] u, logic [31:0] v);
		longint unsigned w, h, fu, fv, x, y, a, b, x0, x1, y0, y1, ta, tb, r1, r2;
		longint unsigned c00[4], c10[4], c01[4], c11[4], res[4];
		tsnb_pkg::texel_t p00, p10, p01, p11;
		if (!present_q) return '0;
		w = clamp_side(width_q);
		h = clamp_side(height_q);
		fu = u[15:0];
		fv = v[15:0];
		if (filt_q == tsnb_pkg::FILT_NEAREST) begin
			x = (fu * (w - 1) + tsnb_pkg::HALF_FX) >> tsnb_pkg::FRAC_BITS;
			y = (((64'd1 << tsnb_pkg::FRAC_BITS) - fv) * (h - 1) + tsnb_pkg::HALF_FX)
				>> tsnb_pkg::FRAC_BITS;
			if (x >= w) x = w - 1;
			if (y >= h) y = h - 1;
			return texel_mem[(x + y * w) & 16383];
		end
		a = fu * w;
		b = fv * h;
		x0 = a >> tsnb_pkg::FRAC_BITS;
		ta = a & 16'hFFFF;
		y0 = b >> tsnb_pkg::FRAC_BITS;
		tb = b & 16'hFFFF;
		x1 = x0 + (ta != 0);
		y1 = y0 + (tb != 0);
		if (x1 >= w) x1 = 0;
		if (y1 >= h) y1 = 0;
		p00 = texel_mem[(x0 + y0 * w) & 16383];
		p10 = texel_mem[(x1 + y0 * w) & 16383];
		p01 = texel_mem[(x0 + y1 * w) & 16383];
		p11 = texel_mem[(x1 + y1 * w) & 16383];
		c00 = '{p00.r, p00.g, p00.b, p00.a};
		c10 = '{p10.r, p10.g, p10.b, p10.a};
		c01 = '{p01.r, p01.g, p01.b, p01.a};
		c11 = '{p11.r, p11.g, p11.b, p11.a};
		for (int k = 0; k < 4; k++) begin
			r1 = blend(c00[k], c10[k], ta);
			r2 = blend(c01[k], c11[k], ta);
			res[k] = blend(r1, r2, tb);
		end
		return '{res[0][16:0], res[1][16:0], res[2][16:0], res[3][16:0]};
	endfunction

	// result checker
	always @(posedge clk) begin
		tsnb_pkg::texel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (rgba_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result r=%0d g=%0d b=%0d a=%0d",
					red_out, green_out, blue_out, alpha_out);
			end else begin
				want = rgba_pending.pop_front();
				if (want.r !== red_out || want.g !== green_out || want.b !== blue_out
						|| want.a !== alpha_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("rgba mismatch: want %0d %0d %0d %0d got %0d %0d %0d %0d",
							want.r, want.g, want.b, want.a,
							red_out, green_out, blue_out, alpha_out);
				end
			end
		end
	end

	task automatic send_item(logic op, logic [13:0] idx, logic [31:0] bytes,
			logic [31:0] u, logic [31:0] v);
		if (!calm && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		texel_index <= idx;
		{byte_three, byte_two, byte_one, byte_zero} <= bytes;
		coord_u <= u;
		coord_v <= v;
		do @(posedge clk); while (in_stall);
		if (op == tsnb_pkg::OP_WRITE)
			texel_mem[idx] = expand_texel(bytes[7:0], bytes[15:8], bytes[23:16],
				bytes[31:24]);
		else
			rgba_pending.push_back(sample_texel(u, v));
	endtask

	// wait for every expected result and let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (rgba_pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tsnb_pkg::CFG_FILTER: filt_q = val[0];
			tsnb_pkg::CFG_CHANNELS: chan_q = val[2:0];
			tsnb_pkg::CFG_WIDTH: width_q = val;
			tsnb_pkg::CFG_HEIGHT: height_q = val;
			tsnb_pkg::CFG_PRESENT: present_q = val[0];
			default: ;
		endcase
	endtask

	task automatic setup(logic f, logic [2:0] ch, logic [7:0] w, logic [7:0] h, logic p);
		settle();
		write_reg(tsnb_pkg::CFG_FILTER, {7'd0, f});
		write_reg(tsnb_pkg::CFG_CHANNELS, {5'd0, ch});
		write_reg(tsnb_pkg::CFG_WIDTH, w);
		write_reg(tsnb_pkg::CFG_HEIGHT, h);
		write_reg(tsnb_pkg::CFG_PRESENT, {7'd0, p});
	endtask

	// every texel that a sample may touch is written first
	task automatic fill_region();
		int n;
		n = int'(clamp_side(width_q) * clamp_side(height_q));
		for (int i = 0; i < n; i++)
			send_item(tsnb_pkg::OP_WRITE, i[13:0], $urandom, '0, '0);
	endtask

	task automatic test_absent();
		send_item(tsnb_pkg::OP_SAMPLE, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(tsnb_pkg::OP_WRITE, 14'h3FFF, 32'hFFFF_FFFF, '0, '0);
		send_item(tsnb_pkg::OP_SAMPLE, '0, '0, '0, '0);
	endtask

	task automatic test_directed();
		logic [31:0] coords [6];
		coords = '{32'h0, 32'hFFFF, 32'h8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1_4000};
		setup(tsnb_pkg::FILT_NEAREST, tsnb_pkg::CH_RGBA, 8'd4, 8'd4, 1'b1);
		send_item(tsnb_pkg::OP_WRITE, 14'd0, 32'h0000_0000, '0, '0);
		send_item(tsnb_pkg::OP_WRITE, 14'd1, 32'hFFFF_FFFF, '0, '0);
		send_item(tsnb_pkg::OP_WRITE, 14'd2, 32'hAA55_00FF, '0, '0);
		for (int i = 3; i < 16; i++)
			send_item(tsnb_pkg::OP_WRITE, i[13:0], $urandom, '0, '0);
		send_item(tsnb_pkg::OP_WRITE, 14'h2AAA, 32'h1234_5678, '0, '0);
		send_item(tsnb_pkg::OP_WRITE, 14'h1555, 32'h8001_7FFE, '0, '0);
		for (int i = 0; i < 6; i++)
			send_item(tsnb_pkg::OP_SAMPLE, '0, '0, coords[i], coords[5 - i]);
		setup(tsnb_pkg::FILT_BILINEAR, tsnb_pkg::CH_RGBA, 8'd4, 8'd4, 1'b1);
		for (int i = 0; i < 6; i++)
			send_item(tsnb_pkg::OP_SAMPLE, '0, '0, coords[i], coords[i]);
	endtask

	task automatic test_phase(logic f, logic [2:0] ch, logic [7:0] w, logic [7:0] h, int n);
		int area;
		setup(f, ch, w, h, 1'b1);
		fill_region();
		area = int'(clamp_side(width_q) * clamp_side(height_q));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 30) begin
				if ($urandom_range(0, 1))
					send_item(tsnb_pkg::OP_WRITE, 14'($urandom_range(0, area - 1)),
						$urandom, $urandom, $urandom);
				else
					send_item(tsnb_pkg::OP_WRITE, 14'($urandom_range(0, 16383)),
						$urandom, $urandom, $urandom);
			end else
				send_item(tsnb_pkg::OP_SAMPLE, 14'($urandom), $urandom, $urandom,
					$urandom);
			if (i == n / 2 && f) settle();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_absent();
		test_directed();
		test_phase(tsnb_pkg::FILT_NEAREST, tsnb_pkg::CH_GREY, 8'd0, 8'd0, 40);
		test_phase(tsnb_pkg::FILT_BILINEAR, tsnb_pkg::CH_GREY_ALPHA, 8'd5, 8'd3, 50);
		test_phase(tsnb_pkg::FILT_NEAREST, tsnb_pkg::CH_RGB, 8'd40, 8'd2, 40);
		calm = 1'b1;
		test_phase(tsnb_pkg::FILT_BILINEAR, tsnb_pkg::CH_RGBA, 8'd7, 8'd6, 60);
		calm = 1'b0;
		test_phase(tsnb_pkg::FILT_BILINEAR, 3'd0, 8'd255, 8'd1, 30);
		test_phase(tsnb_pkg::FILT_NEAREST, 3'd5, 8'd1, 8'd200, 30);
		test_phase(tsnb_pkg::FILT_BILINEAR, 3'd7, 8'd3, 8'd9, 30);
		test_phase(tsnb_pkg::FILT_NEAREST, tsnb_pkg::CH_RGBA, 8'd6, 8'd5, 40);
		test_phase(tsnb_pkg::FILT_BILINEAR, tsnb_pkg::CH_RGB, 8'd2, 8'd2, 50);
		setup(tsnb_pkg::FILT_BILINEAR, tsnb_pkg::CH_RGBA, 8'd2, 8'd2, 1'b0);
		test_absent();
		settle();
		if (mismatches == 0 && rgba_pending.size() == 0)
			$display("texture_sampler_nearest_bilinear_top_tb: done, clean");
		else
			$display("texture_sampler_nearest_bilinear_top_tb: done, errors");
		$finish;
	end

	initial begin
		#(8 * 500000);
		$display("texture_sampler_nearest_bilinear_top_tb: done, errors");
		$finish;
	end

endmodule
